// ===== design/rars_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rars_pkg
// shared constants and types for the range add / range sum unit
// ---------------------------------------------------------------------------
package rars_pkg;
    localparam int Entries    = 1024;
    localparam int IdxW       = $clog2(Entries);
    localparam int NodeW      = IdxW + 1;
    localparam int NodeCount  = 2 * Entries;
    localparam int DataW      = 64;
    localparam int LenW       = IdxW + 1;

    localparam logic [1:0] ModeSet   = 2'd0;
    localparam logic [1:0] ModeAdd   = 2'd1;
    localparam logic [1:0] ModeQuery = 2'd2;
    localparam logic [1:0] ModeNop   = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IdxW-1:0]  lo;
        logic [IdxW:0]    hi;
        logic [DataW-1:0] value;
    } t_req;
endpackage

// ===== design/rars_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rars_req_if / rars_rsp_if
// valid / ready channels for requests and sums
// ---------------------------------------------------------------------------
interface rars_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic [rars_pkg::IdxW-1:0] lo;
    logic [rars_pkg::IdxW:0]   hi;
    logic [63:0]               value;
    modport source (output valid, mode, lo, hi, value, input ready);
    modport sink   (input valid, mode, lo, hi, value, output ready);
endinterface

interface rars_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] range_sum;
    modport source (output valid, range_sum, input ready);
    modport sink   (input valid, range_sum, output ready);
endinterface

// ===== design/rars_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rars_mem
// node store: sum and pending add per node, registered read
// ---------------------------------------------------------------------------
module rars_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [rars_pkg::NodeW-1:0] i_waddr,
    input  logic [63:0]                i_wsum,
    input  logic [63:0]                i_wpend,
    input  logic [rars_pkg::NodeW-1:0] i_raddr,
    output logic [63:0]                o_rsum,
    output logic [63:0]                o_rpend
);
    import rars_pkg::*;

    logic [DataW-1:0] r_sum  [NodeCount];
    logic [DataW-1:0] r_pend [NodeCount];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_sum[i_waddr]  <= i_wsum;
            r_pend[i_waddr] <= i_wpend;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rsum  <= r_sum[i_raddr];
        o_rpend <= r_pend[i_raddr];
    end
endmodule

// ===== design/range_add_range_sum_tree_unit.sv =====
`timescale 1ns / 1ps
// a set walks one root-to-leaf path; add and query stop at the root when it is disjoint or
//   fully covered, else they walk down the ragged ends of the range; a query sum enters the
//   output register at the end of the walk, once that register is free
// throughput: one transaction at a time, the next is accepted once the unit is back in idle
// reset: a clearing pass zeroes all 2*ENTRIES nodes of the node store, no requests accepted then
// the sum result sits in an output register; the next request may enter while it waits
// ---------------------------------------------------------------------------
// range_add_range_sum_tree_unit
// lazy segment tree with point set, range add and range sum over a single node memory
// ---------------------------------------------------------------------------
module range_add_range_sum_tree_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    rars_req_if.sink   i_req,
    rars_rsp_if.source o_rsp
);
    import rars_pkg::*;

    localparam logic [3:0] StClr   = 4'd0;
    localparam logic [3:0] StIdle  = 4'd1;
    localparam logic [3:0] StVisit = 4'd2;
    localparam logic [3:0] StRdP   = 4'd3;
    localparam logic [3:0] StGotP  = 4'd4;
    localparam logic [3:0] StGotL  = 4'd5;
    localparam logic [3:0] StGotR  = 4'd6;
    localparam logic [3:0] StPull  = 4'd7;
    localparam logic [3:0] StPullL = 4'd8;
    localparam logic [3:0] StPullR = 4'd9;
    localparam logic [3:0] StDone  = 4'd10;
    localparam logic [3:0] StLeaf  = 4'd11;
    localparam int DepthW = $clog2(IdxW + 2);

    // explicit recursion stack: node and phase (0 fresh, 1 left done, 2 both done)
    logic [3:0]        r_st, n_st;
    logic [NodeW-1:0]  r_clr;
    logic [NodeW-1:0]  r_stk_p [IdxW+1];
    logic [1:0]        r_stk_ph[IdxW+1];
    logic [DepthW-1:0] r_sp;
    t_req              r_req;
    logic [IdxW:0]     r_hi;
    logic [63:0]       r_acc;
    logic [63:0]       r_ppend, r_lsum;
    logic              r_ovalid;
    logic [63:0]       r_osum;

    logic              mem_we;
    logic [NodeW-1:0]  mem_waddr, mem_raddr;
    logic [63:0]       mem_wsum, mem_wpend, mem_rsum, mem_rpend;

    rars_mem u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wsum (mem_wsum),
        .i_wpend(mem_wpend),
        .i_raddr(mem_raddr),
        .o_rsum (mem_rsum),
        .o_rpend(mem_rpend)
    );

    // span of current node from its index: depth = msb position
    logic [NodeW-1:0] cur_p;
    logic [1:0]       cur_ph;
    logic [LenW-1:0]  cur_l, cur_r, cur_len;
    logic [DepthW-1:0] lvl, sh;
    always_comb begin
        cur_p  = r_stk_p[r_sp[$clog2(IdxW+1)-1:0]];
        cur_ph = r_stk_ph[r_sp[$clog2(IdxW+1)-1:0]];
        lvl = '0;
        for (int b = 0; b < NodeW; b++) begin
            if (cur_p[b]) lvl = DepthW'(b);
        end
        sh       = DepthW'(IdxW) - lvl;
        cur_len  = LenW'(Entries) >> lvl;
        cur_l    = LenW'((LenW'(cur_p) - (LenW'(1) << lvl)) << sh);
        cur_r    = cur_l + cur_len;
    end

    logic disjoint, covered, accept;
    assign disjoint = (cur_l >= r_hi) || (cur_r <= LenW'(r_req.lo));
    assign covered  = (cur_l >= LenW'(r_req.lo)) && (cur_r <= r_hi);
    assign i_req.ready = (r_st == StIdle);
    assign accept = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.range_sum = r_osum;

    // spans are powers of two, so value times length is a shift
    logic [63:0] vmul;
    assign vmul = r_req.value << sh;
    logic [63:0] lmul;
    assign lmul = r_ppend << (sh - 1'b1);

    logic [DepthW-1:0] sp_i;
    assign sp_i = r_sp;

    // finished query moves its sum into the output register once that is free
    logic out_load;
    assign out_load = (r_st == StDone) && (r_sp == '0) && (r_req.mode == ModeQuery)
                      && (!r_ovalid || o_rsp.ready);

    // control and memory access sequencing
    always_comb begin
        n_st      = r_st;
        mem_we    = 1'b0;
        mem_waddr = cur_p;
        mem_wsum  = '0;
        mem_wpend = '0;
        mem_raddr = cur_p;
        case (r_st)
            StClr: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == NodeW'(NodeCount - 1)) n_st = StIdle;
            end
            StIdle: begin
                if (accept && i_req.mode != ModeNop) n_st = StVisit;
            end
            StVisit: begin
                if (cur_ph == 2'd0) begin
                    if (disjoint) n_st = StDone;
                    else if (covered) n_st = StLeaf;
                    else n_st = StRdP;
                end else if (cur_ph == 2'd2) begin
                    n_st = StPull;
                end
            end
            StRdP:  n_st = StGotP;
            StGotP: begin
                mem_raddr = {cur_p[NodeW-2:0], 1'b0};
                n_st = (mem_rpend == '0) ? StVisit : StGotL;
            end
            StGotL: begin
                mem_raddr = {cur_p[NodeW-2:0], 1'b1};
                mem_we    = 1'b1;
                mem_waddr = {cur_p[NodeW-2:0], 1'b0};
                mem_wsum  = mem_rsum + lmul;
                mem_wpend = mem_rpend + r_ppend;
                n_st = StGotR;
            end
            StGotR: begin
                mem_we    = 1'b1;
                mem_waddr = {cur_p[NodeW-2:0], 1'b1};
                mem_wsum  = mem_rsum + lmul;
                mem_wpend = mem_rpend + r_ppend;
                n_st = StVisit;
            end
            StPull:  begin
                mem_raddr = {cur_p[NodeW-2:0], 1'b0};
                n_st = StPullL;
            end
            StPullL: begin
                mem_raddr = {cur_p[NodeW-2:0], 1'b1};
                n_st = StPullR;
            end
            StPullR: begin
                mem_we    = 1'b1;
                mem_wsum  = r_lsum + mem_rsum;
                mem_wpend = '0;
                n_st = StDone;
            end
            StLeaf: begin
                // covered node: set or add writes back, query only reads
                mem_we = (r_req.mode != ModeQuery);
                if (r_req.mode == ModeSet) begin
                    mem_wsum  = r_req.value;
                    mem_wpend = '0;
                end else begin
                    mem_wsum  = mem_rsum + vmul;
                    mem_wpend = mem_rpend + r_req.value;
                end
                n_st = StDone;
            end
            StDone: begin
                if (r_sp != '0) n_st = StVisit;
                else if (r_req.mode != ModeQuery || out_load) n_st = StIdle;
            end
            default: ;
        endcase
    end

    // traversal registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= StClr;
            r_clr    <= '0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == StClr) r_clr <= r_clr + 1'b1;
            if (out_load) begin
                r_ovalid <= 1'b1;
                r_osum   <= r_acc;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                StIdle: if (accept) begin
                    r_req <= '{mode: i_req.mode, lo: i_req.lo, hi: i_req.hi,
                               value: i_req.value};
                    r_hi  <= (i_req.mode == ModeSet) ? (IdxW+1)'(i_req.lo) + 1'b1 :
                             (i_req.hi > (IdxW+1)'(Entries)) ? (IdxW+1)'(Entries) : i_req.hi;
                    r_acc <= '0;
                    r_sp  <= '0;
                    r_stk_p[0]  <= NodeW'(1);
                    r_stk_ph[0] <= 2'd0;
                end
                StVisit: begin
                    if (cur_ph == 2'd1) begin
                        r_stk_ph[sp_i[$clog2(IdxW+1)-1:0]] <= 2'd2;
                        r_stk_p[sp_i[$clog2(IdxW+1)-1:0] + 1'b1] <=
                            {cur_p[NodeW-2:0], 1'b1};
                        r_stk_ph[sp_i[$clog2(IdxW+1)-1:0] + 1'b1] <= 2'd0;
                        r_sp <= r_sp + 1'b1;
                    end
                end
                StGotP: begin
                    r_ppend <= mem_rpend;
                    // when parent pending was zero, skip to descending left
                    if (mem_rpend == '0) begin
                        r_stk_ph[sp_i[$clog2(IdxW+1)-1:0]] <= 2'd1;
                        r_stk_p[sp_i[$clog2(IdxW+1)-1:0] + 1'b1] <=
                            {cur_p[NodeW-2:0], 1'b0};
                        r_stk_ph[sp_i[$clog2(IdxW+1)-1:0] + 1'b1] <= 2'd0;
                        r_sp <= r_sp + 1'b1;
                    end
                end
                StGotR: begin
                    // descend into left child, parent pending cleared by its pull-up
                    r_stk_ph[sp_i[$clog2(IdxW+1)-1:0]] <= 2'd1;
                    r_stk_p[sp_i[$clog2(IdxW+1)-1:0] + 1'b1] <= {cur_p[NodeW-2:0], 1'b0};
                    r_stk_ph[sp_i[$clog2(IdxW+1)-1:0] + 1'b1] <= 2'd0;
                    r_sp <= r_sp + 1'b1;
                end
                StPullL: r_lsum <= mem_rsum;
                StLeaf: if (r_req.mode == ModeQuery) r_acc <= r_acc + mem_rsum;
                StDone: if (r_sp != '0) r_sp <= r_sp - 1'b1;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // no transaction accepted during clearing
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == StClr) |-> !i_req.ready)
        else $error("request accepted during clear");
    // result register holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.range_sum)))
        else $error("result dropped");
    // result only raised at end of a query
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> ($past(r_st) == StDone && r_req.mode == ModeQuery))
        else $error("spurious result");
`endif
endmodule
